FILE: rtl/rpn_pkg.sv
package rpn_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned ST_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5,
    OP_END  = 3'd6,
    OP_BAD  = 3'd7
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_RESULT   = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_DIVZERO  = 3'd4,
    ST_MODZERO  = 3'd5,
    ST_INVALID  = 3'd6,
    ST_DISCARD  = 3'd7
  } status_t;

  typedef struct packed {
    logic start;
    logic mode_mul;
  } alu_ctl_t;

endpackage

FILE: rtl/rpn_stack_calculator.sv
// Postfix evaluator: one token per transaction on s_axis, one result per token on
// m_axis. Tokens are taken one at a time. Every token passes the two operand
// reads; push, end, add and subtract tokens then offer their result straight
// from the execute state, while multiply, divide and modulo wait for the 16-step
// bit-serial unit and offer theirs on its done handoff. s_axis is ready again in
// the cycle after the result leaves.
// The operand stack lives in a registered-read RAM, two reads per operator.
module rpn_stack_calculator
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [2:0] op, [18:3] number, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // [2:0] status, [18:3] value, zero pad
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_RDB, S_RDA, S_EXEC, S_WAIT, S_OUT} state_t;

  state_t            state;
  op_t               op;
  logic [WORD_W-1:0] num;
  logic [CW-1:0]     count;
  logic              err;
  logic [WORD_W-1:0] ra;
  logic [WORD_W-1:0] rb;
  status_t           ost;
  logic [WORD_W-1:0] oval;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [WORD_W-1:0] rdata;

  alu_ctl_t          actl;
  logic              adone;
  logic [WORD_W-1:0] aquo;
  logic [WORD_W-1:0] arem;
  logic [WORD_W-1:0] ua;
  logic [WORD_W-1:0] ub;
  logic [WORD_W-1:0] res;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {5'd0, oval, ost};

  rpn_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  rpn_alu u_alu (
    .clk(clk), .rst(rst), .ctl(actl), .a(ua), .b(ub),
    .done(adone), .quo(aquo), .rem(arem)
  );

  // magnitudes for divide; multiply uses raw bits
  assign ua = (op == OP_MUL || !ra[WORD_W-1]) ? ra : -ra;
  assign ub = (op == OP_MUL || !rb[WORD_W-1]) ? rb : -rb;

  always_comb begin
    case (op)
      OP_MUL:  res = aquo;
      OP_DIV:  res = (ra[WORD_W-1] ^ rb[WORD_W-1]) ? -aquo : aquo;
      default: res = ra[WORD_W-1] ? -arem : arem;
    endcase
  end

  always_comb begin
    raddr = '0;
    if (state == S_IDLE || state == S_RDB) begin
      raddr = AW'(count - CW'(1));
    end
    if (state == S_RDB) begin
      raddr = AW'(count - CW'(2));
    end
    if (state == S_IDLE) begin
      raddr = AW'(count - CW'(1));
    end
  end

  assign actl = '{
    start:    (state == S_EXEC) && (op == OP_MUL || op == OP_DIV || op == OP_MOD),
    mode_mul: (op == OP_MUL)
  };

  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      err   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op    <= op_t'(s_axis_tdata[2:0]);
            num   <= s_axis_tdata[18:3];
            state <= S_RDB;
          end
        end
        S_RDB: begin
          rb    <= rdata;
          state <= S_RDA;
        end
        S_RDA: begin
          ra    <= rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          oval  <= '0;
          state <= S_OUT;
          if (op == OP_END) begin
            count <= '0;
            err   <= 1'b0;
            if (err) begin
              ost <= ST_DISCARD;
            end else if (count == CW'(1)) begin
              ost  <= ST_RESULT;
              oval <= rb;
            end else begin
              ost <= ST_INVALID;
            end
          end else if (err) begin
            ost <= ST_DISCARD;
          end else if (op == OP_PUSH) begin
            if (count >= CW'(STACK_DEPTH)) begin
              ost <= ST_OVERFLOW;
              err <= 1'b1;
            end else begin
              ost   <= ST_OK;
              oval  <= num;
              we    <= 1'b1;
              waddr <= AW'(count);
              wdata <= num;
              count <= count + CW'(1);
            end
          end else if (op == OP_BAD) begin
            ost <= ST_INVALID;
            err <= 1'b1;
          end else if (count < CW'(2)) begin
            ost <= ST_UNDERFLOW;
            err <= 1'b1;
          end else if (op == OP_DIV && rb == '0) begin
            ost <= ST_DIVZERO;
            err <= 1'b1;
          end else if (op == OP_MOD && rb == '0) begin
            ost <= ST_MODZERO;
            err <= 1'b1;
          end else if (op == OP_ADD || op == OP_SUB) begin
            ost   <= ST_OK;
            oval  <= (op == OP_ADD) ? ra + rb : ra - rb;
            we    <= 1'b1;
            waddr <= AW'(count - CW'(2));
            wdata <= (op == OP_ADD) ? ra + rb : ra - rb;
            count <= count - CW'(1);
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (adone) begin
            ost   <= ST_OK;
            oval  <= res;
            we    <= 1'b1;
            waddr <= AW'(count - CW'(2));
            wdata <= res;
            count <= count - CW'(1);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/rpn_ram.sv
module rpn_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/rpn_alu.sv
// Bit-serial multiply (shift-add) and unsigned divide (shift-subtract), 16 steps.
module rpn_alu
  import rpn_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  alu_ctl_t          ctl,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic              done,
  output logic [WORD_W-1:0] quo,
  output logic [WORD_W-1:0] rem
);

  localparam int unsigned CNT_W = $clog2(WORD_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              mul;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] sh;
  logic [WORD_W-1:0] dv;
  logic [WORD_W:0]   trial;

  assign trial = {acc, sh[WORD_W-1]} - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        mul  <= ctl.mode_mul;
        cnt  <= CNT_W'(WORD_W);
        acc  <= '0;
        sh   <= a;
        dv   <= b;
      end else if (busy) begin
        if (mul) begin
          // multiplier bits from sh msb first; result built low word only
          acc <= (acc << 1) + (sh[WORD_W-1] ? dv : '0);
          sh  <= sh << 1;
        end else begin
          if (!trial[WORD_W]) begin
            acc <= trial[WORD_W-1:0];
            sh  <= {sh[WORD_W-2:0], 1'b1};
          end else begin
            acc <= {acc[WORD_W-2:0], sh[WORD_W-1]};
            sh  <= {sh[WORD_W-2:0], 1'b0};
          end
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = mul ? acc : sh;
  assign rem = acc;

endmodule

FILE: test/rpn_stack_calculator_test.sv
module rpn_stack_calculator_test;
  import rpn_pkg::*;

  localparam int unsigned DEPTH = 128;
  localparam int unsigned RANDOM_TOKENS = 540;

  typedef struct packed {
    status_t     status;
    logic [15:0] value;
  } outcome_t;

  typedef struct {
    op_t         op;
    logic [15:0] number;
    logic        known;
    status_t     status;
    logic [15:0] value;
  } row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  logic [15:0] operands [DEPTH];
  int unsigned depth_used;
  logic        sticky_err;
  outcome_t    pending [$];
  int unsigned error_count;
  bit          calm;
  int unsigned hold_left;

  rpn_stack_calculator #(.STACK_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic outcome_t evaluate(op_t op, logic [15:0] num);
    outcome_t    res;
    logic [15:0] a, b, r;
    int unsigned cnt;
    cnt = depth_used;
    res.status = ST_OK;
    res.value = '0;
    if (op == OP_END) begin
      res.status = sticky_err ? ST_DISCARD : (cnt == 1) ? ST_RESULT : ST_INVALID;
      if (res.status == ST_RESULT) res.value = operands[0];
      depth_used = 0;
      sticky_err = 1'b0;
      return res;
    end
    if (sticky_err) begin
      res.status = ST_DISCARD;
      return res;
    end
    if (op == OP_PUSH) begin
      if (cnt >= DEPTH) begin
        sticky_err = 1'b1;
        res.status = ST_OVERFLOW;
      end else begin
        operands[cnt] = num;
        depth_used = cnt + 1;
        res.value = num;
      end
      return res;
    end
    if (op == OP_BAD) begin
      sticky_err = 1'b1;
      res.status = ST_INVALID;
      return res;
    end
    if (cnt < 2) begin
      sticky_err = 1'b1;
      res.status = ST_UNDERFLOW;
      return res;
    end
    a = operands[cnt-2];
    b = operands[cnt-1];
    if ((op == OP_DIV || op == OP_MOD) && b == 16'd0) begin
      sticky_err = 1'b1;
      res.status = (op == OP_DIV) ? ST_DIVZERO : ST_MODZERO;
      return res;
    end
    case (op)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: r = a * b;
      // wrap the most negative value over minus one explicitly
      OP_DIV: r = (a == 16'h8000 && b == 16'hFFFF) ? 16'h8000 : 16'($signed(a) / $signed(b));
      default: r = (b == 16'hFFFF) ? 16'd0 : 16'($signed(a) % $signed(b));
    endcase
    operands[cnt-2] = r;
    depth_used = cnt - 1;
    res.value = r;
    return res;
  endfunction

  task automatic idle_burst();
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drop_valid();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic send_token(op_t op, logic [15:0] num);
    idle_burst();
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, num, op};
    do @(posedge clk); while (!s_axis_tready);
    pending.push_back(evaluate(op, num));
  endtask

  // receiver with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending.size() == 0) begin
          $error("result with no token outstanding: %h", m_axis_tdata);
          error_count++;
        end else begin
          if (m_axis_tdata[2:0] !== pending[0].status) begin
            $error("status expected %0d actual %0d", pending[0].status, m_axis_tdata[2:0]);
            error_count++;
          end
          if (m_axis_tdata[18:3] !== pending[0].value) begin
            $error("value expected %h actual %h", pending[0].value, m_axis_tdata[18:3]);
            error_count++;
          end
          void'(pending.pop_front());
        end
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        hold_left <= $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic check_row(row_t row);
    send_token(row.op, row.number);
    if (row.known && (pending[$].status !== row.status || pending[$].value !== row.value)) begin
      $error("row expectation: status %0d value %h, predicted %0d %h",
             row.status, row.value, pending[$].status, pending[$].value);
      error_count++;
    end
  endtask

  function automatic op_t pick_op();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 45) return OP_PUSH;
    if (k < 85) return op_t'($urandom_range(1, 5));
    if (k < 97) return OP_END;
    return OP_BAD;
  endfunction

  function automatic logic [15:0] pick_number();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  row_t table_rows [] = '{
    '{OP_END,  16'h0000, 1'b1, ST_INVALID,   16'h0000},
    '{OP_ADD,  16'h0000, 1'b1, ST_UNDERFLOW, 16'h0000},
    '{OP_PUSH, 16'h1234, 1'b1, ST_DISCARD,   16'h0000},
    '{OP_END,  16'h0000, 1'b1, ST_DISCARD,   16'h0000},
    '{OP_PUSH, 16'h7FFF, 1'b1, ST_OK,        16'h7FFF},
    '{OP_END,  16'hFFFF, 1'b1, ST_RESULT,    16'h7FFF},
    '{OP_PUSH, 16'h8000, 1'b1, ST_OK,        16'h8000},
    '{OP_PUSH, 16'hFFFF, 1'b1, ST_OK,        16'hFFFF},
    '{OP_DIV,  16'h0000, 1'b1, ST_OK,        16'h8000},
    '{OP_PUSH, 16'hFFFF, 1'b0, ST_OK,        16'h0000},
    '{OP_MOD,  16'h0000, 1'b1, ST_OK,        16'h0000},
    '{OP_PUSH, 16'h0007, 1'b0, ST_OK,        16'h0000},
    '{OP_ADD,  16'h0000, 1'b0, ST_OK,        16'h0000},
    '{OP_PUSH, 16'hFFFD, 1'b0, ST_OK,        16'h0000},
    '{OP_MUL,  16'h0000, 1'b0, ST_OK,        16'h0000},
    '{OP_PUSH, 16'h0002, 1'b0, ST_OK,        16'h0000},
    '{OP_SUB,  16'h0000, 1'b0, ST_OK,        16'h0000},
    '{OP_PUSH, 16'h0000, 1'b0, ST_OK,        16'h0000},
    '{OP_DIV,  16'h0000, 1'b1, ST_DIVZERO,   16'h0000},
    '{OP_END,  16'h0000, 1'b1, ST_DISCARD,   16'h0000},
    '{OP_PUSH, 16'h0005, 1'b1, ST_OK,        16'h0005},
    '{OP_PUSH, 16'h0000, 1'b1, ST_OK,        16'h0000},
    '{OP_MOD,  16'h0000, 1'b1, ST_MODZERO,   16'h0000},
    '{OP_END,  16'h0000, 1'b1, ST_DISCARD,   16'h0000},
    '{OP_BAD,  16'h0000, 1'b1, ST_INVALID,   16'h0000}
  };

  initial begin
    int unsigned n, stall;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    depth_used = 0;
    sticky_err = 1'b0;
    error_count = 0;
    calm = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (table_rows[i]) check_row(table_rows[i]);
    send_token(OP_END, 16'h0);

    // fill to the top, then overflow
    for (int i = 0; i < DEPTH; i++) send_token(OP_PUSH, 16'($urandom));
    send_token(OP_PUSH, 16'h5555);
    send_token(OP_END, 16'h0);
    for (int i = 0; i < DEPTH; i++) send_token(OP_PUSH, 16'($urandom));
    for (int i = 1; i < DEPTH; i++) send_token(op_t'($urandom_range(1, 3)), 16'hAAAA);
    send_token(OP_END, 16'h0);
    drop_valid();

    // hold off until every result is back
    stall = 0;
    while (pending.size() != 0 && stall < 100000) begin
      @(posedge clk);
      stall++;
    end

    n = 0;
    while (n < RANDOM_TOKENS) begin
      if (n > RANDOM_TOKENS * 9 / 10) calm = 1'b1;
      if ($urandom_range(0, 9) < 8) begin
        // well-formed expression: one operand, then operand and operator pairs, then end
        int unsigned k;
        k = $urandom_range(1, 6);
        send_token(OP_PUSH, pick_number());
        n++;
        for (int j = 1; j < k; j++) begin
          send_token(OP_PUSH, pick_number());
          send_token(op_t'($urandom_range(1, 5)), 16'($urandom));
          n += 2;
        end
        send_token(OP_END, 16'($urandom));
        n++;
      end else begin
        send_token(pick_op(), pick_number());
        n++;
      end
    end
    drop_valid();

    stall = 0;
    while (pending.size() != 0 && stall < 100000) begin
      @(posedge clk);
      stall++;
    end
    repeat (40) @(posedge clk);
    if (error_count == 0 && pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
